### hdl/bwt_pkg.sv
// Package for the cyclic rotation BWT block: controller command and status types.
// Depends on nothing; used by the controller, datapath and top level.
`timescale 1ns / 1ps
package bwt_pkg;
  typedef struct packed {
    logic store;     // write the input byte at the fill count
    logic set_ovf;   // a byte was dropped
    logic clr_len;   // clear fill count and overflow flag
    logic init_i;    // i := 0
    logic inc_i;     // i := i + 1
    logic init_j;    // j := i, cur := i
    logic start_cmp; // load comparison pointers for cur and order[j-1]
    logic step_cmp;  // advance comparison by one character
    logic shift;     // order[j] := order[j-1], j := j - 1
    logic place;     // order[j] := cur
    logic rd_order;  // read order[j-1] (or order[i] when emitting)
    logic rd_text_a; // read text at pointer a
    logic rd_text_b; // read text at pointer b
    logic emit_rd;   // read text at prev of order[i]
  } bwt_cmd_t;

  typedef struct packed {
    logic full;      // fill count reached MAX_LEN
    logic i_done;    // i == len
    logic j_zero;    // j == 0
    logic chars_ne;  // the characters being compared differ
    logic a_less;    // character a is below character b
    logic k_done;    // len characters compared
    logic a_gt_b;    // start of cur above start of order[j-1]
    logic i_last;    // i == len - 1
  } bwt_sts_t;
endpackage

### hdl/bwt_ram.sv
// Generic single write, single read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps
module bwt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hdl/bwt_datapath.sv
// Datapath of the BWT block: text and order memories, counters and comparator.
// Depends on bwt_pkg and bwt_ram.
`timescale 1ns / 1ps
module bwt_datapath import bwt_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  bwt_cmd_t   cmd,
  output bwt_sts_t   sts,
  input  logic [7:0] in_ch,
  output logic [7:0] ch_q,
  output logic       ovf_q
);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);

  logic [CW-1:0] len_r, i_r, j_r, k_r;
  logic [AW-1:0] cur_r, pa_r, pb_r, bstart_r;
  logic          ovf_r;
  logic [AW-1:0] order_raddr, order_waddr, order_wdata, order_q;
  logic [AW-1:0] text_raddr, text_waddr;
  logic [7:0]    text_q, ca_r;
  logic          order_we;
  logic [AW-1:0] lenm1, nxt_a, nxt_b, prev;

  assign lenm1 = AW'(len_r - CW'(1));
  assign nxt_a = (pa_r == lenm1) ? '0 : pa_r + AW'(1);
  assign nxt_b = (pb_r == lenm1) ? '0 : pb_r + AW'(1);
  assign prev  = (order_q == '0) ? lenm1 : order_q - AW'(1);

  always_comb begin
    text_waddr = AW'(len_r);
    if (cmd.emit_rd) text_raddr = prev;
    else if (cmd.rd_text_b) text_raddr = pb_r;
    else text_raddr = pa_r;
    order_raddr = cmd.inc_i ? AW'(i_r) : AW'(j_r - CW'(1));
    if (cmd.rd_order && cmd.emit_rd) order_raddr = AW'(i_r);
    order_we    = cmd.shift | cmd.place;
    order_waddr = AW'(j_r);
    order_wdata = cmd.shift ? order_q : cur_r;
  end

  bwt_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_text (
    .clk, .we(cmd.store), .waddr(text_waddr), .wdata(in_ch),
    .raddr(text_raddr), .rdata(text_q));
  bwt_ram #(.WIDTH(AW), .DEPTH(MAX_LEN)) u_order (
    .clk, .we(order_we), .waddr(order_waddr), .wdata(order_wdata),
    .raddr(order_raddr), .rdata(order_q));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      if (cmd.store) len_r <= len_r + CW'(1);
      if (cmd.set_ovf) ovf_r <= 1'b1;
      if (cmd.clr_len) begin
        len_r <= '0;
        ovf_r <= 1'b0;
      end
    end
    if (cmd.init_i) i_r <= '0;
    if (cmd.inc_i) i_r <= i_r + CW'(1);
    if (cmd.init_j) begin
      j_r   <= i_r;
      cur_r <= AW'(i_r);
    end
    if (cmd.shift) j_r <= j_r - CW'(1);
    if (cmd.start_cmp) begin
      pa_r     <= cur_r;
      pb_r     <= order_q;
      bstart_r <= order_q;
      k_r      <= '0;
    end
    if (cmd.rd_text_b) ca_r <= text_q;
    if (cmd.step_cmp) begin
      pa_r <= nxt_a;
      pb_r <= nxt_b;
      k_r  <= k_r + CW'(1);
    end
  end

  assign sts.full     = (len_r == CW'(MAX_LEN));
  assign sts.i_done   = (i_r == len_r);
  assign sts.i_last   = (i_r == len_r - CW'(1));
  assign sts.j_zero   = (j_r == '0);
  assign sts.chars_ne = (ca_r != text_q);
  assign sts.a_less   = (ca_r < text_q);
  assign sts.k_done   = (k_r == len_r);
  assign sts.a_gt_b   = (cur_r > bstart_r);
  assign ch_q  = text_q;
  assign ovf_q = ovf_r;
endmodule

### hdl/bwt_ctrl.sv
// Controller of the BWT block: load, insertion sort sequencing and output.
// Depends on bwt_pkg.
`timescale 1ns / 1ps
module bwt_ctrl import bwt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_last,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     out_last_out,
  output logic     ld_out,
  output bwt_cmd_t cmd,
  input  bwt_sts_t sts
);
  typedef enum logic [3:0] {
    S_LOAD, S_ROW, S_JCHK, S_RDB, S_START, S_RDA, S_CMP,
    S_ERD, S_ERD2, S_EOUT
  } state_t;
  state_t state_r, state_nxt;
  logic   valid_r, valid_nxt, lastf_r, lastf_nxt;

  assign in_ready     = (state_r == S_LOAD);
  assign out_valid    = valid_r;
  assign out_last_out = lastf_r;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = valid_r;
    lastf_nxt = lastf_r;
    cmd       = '0;
    ld_out    = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          cmd.store   = !sts.full;
          cmd.set_ovf = sts.full;
          if (in_last) begin
            cmd.init_i = 1'b1;
            state_nxt  = S_ROW;
          end
        end
      end
      S_ROW: begin
        if (sts.i_done) begin
          cmd.init_i = 1'b1;
          state_nxt  = S_ERD;
        end else begin
          cmd.init_j = 1'b1;
          state_nxt  = S_JCHK;
        end
      end
      S_JCHK: begin
        if (sts.j_zero) begin
          cmd.place = 1'b1;
          cmd.inc_i = 1'b1;
          state_nxt = S_ROW;
        end else begin
          cmd.rd_order = 1'b1;
          state_nxt    = S_START;
        end
      end
      S_START: begin
        cmd.start_cmp = 1'b1;
        state_nxt     = S_RDA;
      end
      S_RDA: begin
        cmd.rd_text_a = 1'b1;
        state_nxt     = S_RDB;
      end
      S_RDB: begin
        cmd.rd_text_b = 1'b1;
        state_nxt     = S_CMP;
      end
      S_CMP: begin
        if (sts.k_done || sts.chars_ne) begin
          if (sts.chars_ne ? sts.a_less : sts.a_gt_b) begin
            cmd.rd_order = 1'b1;
            cmd.shift    = 1'b1;
            state_nxt    = S_JCHK;
          end else begin
            cmd.place = 1'b1;
            cmd.inc_i = 1'b1;
            state_nxt = S_ROW;
          end
        end else if (sts.k_done) begin
          state_nxt = S_ROW;
        end else begin
          cmd.step_cmp = 1'b1;
          state_nxt    = S_RDA;
        end
      end
      S_ERD: begin
        cmd.rd_order = 1'b1;
        cmd.emit_rd  = 1'b1;
        state_nxt    = S_ERD2;
      end
      S_ERD2: begin
        cmd.emit_rd = 1'b1;
        state_nxt   = S_EOUT;
      end
      S_EOUT: begin
        if (!valid_r) begin
          valid_nxt = 1'b1;
          lastf_nxt = sts.i_last;
          ld_out    = 1'b1;
        end else if (out_ready) begin
          valid_nxt = 1'b0;
          cmd.inc_i = 1'b1;
          if (lastf_r) begin
            cmd.clr_len = 1'b1;
            state_nxt   = S_LOAD;
          end else begin
            state_nxt = S_ERD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      valid_r <= 1'b0;
      lastf_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      lastf_r <= lastf_nxt;
    end
  end
endmodule

### hdl/cyclic_rotation_bwt.sv
// Top level of the cyclic rotation BWT block.
// Depends on bwt_pkg, bwt_ctrl and bwt_datapath.
//
// Input bytes arrive on in_ch with in_last on a valid/ready channel, one
// transaction per cycle while loading. Bytes beyond MAX_LEN are dropped and
// set the overflow flag. The final byte starts an insertion sort of the
// rotation start positions; each comparison walks the text memory one
// character at a time through the states S_RDA, S_RDB and S_CMP.
// Then n result transactions follow on out_ch_out with out_last_out on the
// last one, each read in S_ERD and S_ERD2 and registered in S_EOUT. While the
// receiver stalls, the result is held and the block waits. Input is not
// accepted from the final byte until the last result is taken. Synchronous
// reset clears the fill count, the overflow flag and the handshakes.
`timescale 1ns / 1ps
module cyclic_rotation_bwt import bwt_pkg::*; #(
  parameter int MAX_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_ch_out,
  output logic       out_last_out,
  output logic       out_overflow
);
  bwt_cmd_t   cmd;
  bwt_sts_t   sts;
  logic       ld_out;
  logic [7:0] ch_q, ch_r;
  logic       ovf_q, ovf_r;

  bwt_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_last, .out_valid, .out_ready,
    .out_last_out, .ld_out, .cmd, .sts);
  bwt_datapath #(.MAX_LEN(MAX_LEN)) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_ch, .ch_q, .ovf_q);

  always_ff @(posedge clk) begin
    if (ld_out) begin
      ch_r  <= ch_q;
      ovf_r <= ovf_q;
    end
  end
  assign out_ch_out   = ch_r;
  assign out_overflow = ovf_r;
endmodule
